>>> rtl/crec_pkg.sv
// ----------------------------------------------------------------------------
// crec_pkg
// Shared sizes, field widths and the command/status bundles that link the
// controller and the datapath of the cyclic relabeling equivalence check.
// ----------------------------------------------------------------------------
`default_nettype none

package crec_pkg;

    // Sequence and label limits
    localparam int MAX_LEN   = 64;
    localparam int MAX_LABEL = 64;

    // Payload field widths
    localparam int LABEL_W = 7;
    localparam int SHIFT_W = 6;

    // Derived widths
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int LBL_IDX_W = $clog2(MAX_LABEL + 1);

    // Controller to datapath
    typedef struct packed {
        logic search_init;  // zero the shift counter
        logic shift_init;   // clear map marks, rewind element and rotation pointers
        logic commit;       // record the current label pair in the map
        logic next_elem;    // advance element and rotation pointers
        logic next_shift;   // advance to the next rotation
        logic emit;         // load the result register
        logic found;        // result value for emit
    } crec_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mismatch;     // stored lengths differ or reference empty
        logic bad_label;    // fetched label lies above MAX_LABEL
        logic conflict;     // current label pair breaks the one-to-one map
        logic last_elem;    // current element is the last of the sequence
        logic last_shift;   // current rotation is the last one
        logic out_free;     // result register can take a new transaction
    } crec_status_t;

endpackage

`default_nettype wire

>>> rtl/crec_if.sv
// ----------------------------------------------------------------------------
// crec_if
// Valid/ready channels: label input and check result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface crec_label_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [crec_pkg::LABEL_W-1:0]  label;
    logic                          last;

    modport source (output valid, output req_type, output label, output last,
                    input ready);
    modport sink   (input valid, input req_type, input label, input last,
                    output ready);
endinterface

interface crec_result_if;
    logic                          valid;
    logic                          ready;
    logic                          equivalent;
    logic [crec_pkg::SHIFT_W-1:0]  shift_found;
    logic                          length_mismatch;
    logic                          overflow;

    modport source (output valid, output equivalent, output shift_found,
                    output length_mismatch, output overflow, input ready);
    modport sink   (input valid, input equivalent, input shift_found,
                    input length_mismatch, input overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/crec_ctrl.sv
// ----------------------------------------------------------------------------
// crec_ctrl
// Sequencer for the shift search: loads labels while idle, then walks
// rotations and elements through the datapath and issues the result.
// ----------------------------------------------------------------------------
`default_nettype none

module crec_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire logic                   req_type,
    input  wire logic                   last,
    input  wire crec_pkg::crec_status_t status,
    output logic                        in_ready,
    output crec_pkg::crec_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_CLR   = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_MAP   = 3'd4;
    localparam logic [2:0] ST_CMP   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       found_reg;
    logic       found_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        found_next = found_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_type && last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                found_next = 1'b0;
                if (status.mismatch)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.search_init = 1'b1;
                    state_next      = ST_CLR;
                end
            end
            ST_CLR:
            begin
                cmd.shift_init = 1'b1;
                state_next     = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_MAP;
            end
            ST_MAP:
            begin
                if (!status.bad_label)
                begin
                    state_next = ST_CMP;
                end
                else if (status.last_shift)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.next_shift = 1'b1;
                    state_next     = ST_CLR;
                end
            end
            ST_CMP:
            begin
                if (!status.conflict)
                begin
                    cmd.commit = 1'b1;
                    if (status.last_elem)
                    begin
                        found_next = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        cmd.next_elem = 1'b1;
                        state_next    = ST_RD;
                    end
                end
                else if (status.last_shift)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.next_shift = 1'b1;
                    state_next     = ST_CLR;
                end
            end
            ST_OUT:
            begin
                cmd.found = found_reg;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/crec_dp.sv
// ----------------------------------------------------------------------------
// crec_dp
// Sequence stores, length and overflow tracking, rotation/element pointers,
// label map with valid and used marks, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module crec_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire crec_pkg::crec_cmd_t           cmd,
    output crec_pkg::crec_status_t             status,
    input  wire logic                          accept,
    input  wire logic                          req_type,
    input  wire logic [crec_pkg::LABEL_W-1:0]  label,
    input  wire logic                          last,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic                               equivalent,
    output logic [crec_pkg::SHIFT_W-1:0]       shift_found,
    output logic                               length_mismatch,
    output logic                               overflow
);

    // Sequence stores
    logic [crec_pkg::LABEL_W-1:0] ref_mem  [crec_pkg::MAX_LEN];
    logic [crec_pkg::LABEL_W-1:0] cand_mem [crec_pkg::MAX_LEN];
    logic [crec_pkg::LABEL_W-1:0] ref_rd_reg;
    logic [crec_pkg::LABEL_W-1:0] cand_rd_reg;

    // Lengths and overflow marks
    logic [crec_pkg::LEN_W-1:0]   ref_len_reg;
    logic [crec_pkg::LEN_W-1:0]   cand_len_reg;
    logic                         ref_ovf_reg;
    logic                         cand_ovf_reg;
    logic                         ref_done_reg;

    // Search pointers
    logic [crec_pkg::ADDR_W-1:0]  k_reg;
    logic [crec_pkg::ADDR_W-1:0]  i_reg;
    logic [crec_pkg::ADDR_W-1:0]  r_reg;

    // Label map
    logic [crec_pkg::LABEL_W-1:0] map_mem [crec_pkg::MAX_LABEL + 1];
    logic [crec_pkg::LABEL_W-1:0] map_rd_reg;
    logic [crec_pkg::MAX_LABEL:0] map_valid_reg;
    logic [crec_pkg::MAX_LABEL:0] map_used_reg;

    // Result register
    logic                         out_valid_reg;
    logic                         equivalent_reg;
    logic [crec_pkg::SHIFT_W-1:0] shift_reg;
    logic                         mismatch_reg;
    logic                         overflow_reg;

    logic [crec_pkg::LEN_W-1:0]     ref_base;
    logic                           ref_room;
    logic                           ref_wr;
    logic                           cand_room;
    logic                           cand_wr;
    logic [crec_pkg::LBL_IDX_W-1:0] y_idx;
    logic [crec_pkg::LBL_IDX_W-1:0] x_idx;
    logic                           r_wrap;
    logic                           len_mismatch;

    // A reference label after a finished reference starts a new one
    assign ref_base  = ref_done_reg ? '0 : ref_len_reg;
    assign ref_room  = (32'(ref_base) < crec_pkg::MAX_LEN);
    assign ref_wr    = accept && !req_type && ref_room;
    assign cand_room = (32'(cand_len_reg) < crec_pkg::MAX_LEN);
    assign cand_wr   = accept && req_type && cand_room;

    assign y_idx  = crec_pkg::LBL_IDX_W'(ref_rd_reg);
    assign x_idx  = crec_pkg::LBL_IDX_W'(cand_rd_reg);
    assign r_wrap = ((crec_pkg::LEN_W'(r_reg) + crec_pkg::LEN_W'(1)) == cand_len_reg);

    assign len_mismatch = (ref_len_reg != cand_len_reg) || (ref_len_reg == '0);

    assign status.mismatch   = len_mismatch;
    assign status.bad_label  = (32'(ref_rd_reg) > crec_pkg::MAX_LABEL)
                            || (32'(cand_rd_reg) > crec_pkg::MAX_LABEL);
    assign status.conflict   = map_valid_reg[y_idx] ? (map_rd_reg != cand_rd_reg)
                                                    : map_used_reg[x_idx];
    assign status.last_elem  = ((crec_pkg::LEN_W'(i_reg) + crec_pkg::LEN_W'(1))
                                == cand_len_reg);
    assign status.last_shift = ((crec_pkg::LEN_W'(k_reg) + crec_pkg::LEN_W'(1))
                                == cand_len_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

    // Sequence memories: one write port for loading, one registered read port
    always_ff @(posedge clk)
    begin
        if (ref_wr)
        begin
            ref_mem[ref_base[crec_pkg::ADDR_W-1:0]] <= label;
        end
        if (cand_wr)
        begin
            cand_mem[cand_len_reg[crec_pkg::ADDR_W-1:0]] <= label;
        end
        ref_rd_reg  <= ref_mem[r_reg];
        cand_rd_reg <= cand_mem[i_reg];
    end

    // Label map memory: written on a fresh pairing, read at the reference label
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !map_valid_reg[y_idx])
        begin
            map_mem[y_idx] <= cand_rd_reg;
        end
        map_rd_reg <= map_mem[y_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_len_reg   <= '0;
            cand_len_reg  <= '0;
            ref_ovf_reg   <= 1'b0;
            cand_ovf_reg  <= 1'b0;
            ref_done_reg  <= 1'b0;
            k_reg         <= '0;
            i_reg         <= '0;
            r_reg         <= '0;
            map_valid_reg <= '0;
            map_used_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Reference load
            if (accept && !req_type)
            begin
                ref_len_reg  <= ref_room ? ref_base + crec_pkg::LEN_W'(1) : ref_base;
                ref_ovf_reg  <= (ref_done_reg ? 1'b0 : ref_ovf_reg) || !ref_room;
                ref_done_reg <= last;
            end

            // Candidate load; drop the candidate once its result goes out
            if (cmd.emit)
            begin
                cand_len_reg <= '0;
                cand_ovf_reg <= 1'b0;
            end
            else if (accept && req_type)
            begin
                if (cand_room)
                begin
                    cand_len_reg <= cand_len_reg + crec_pkg::LEN_W'(1);
                end
                else
                begin
                    cand_ovf_reg <= 1'b1;
                end
            end

            // Rotation and element pointers
            if (cmd.search_init)
            begin
                k_reg <= '0;
            end
            else if (cmd.next_shift)
            begin
                k_reg <= k_reg + crec_pkg::ADDR_W'(1);
            end

            if (cmd.shift_init)
            begin
                i_reg         <= '0;
                r_reg         <= k_reg;
                map_valid_reg <= '0;
                map_used_reg  <= '0;
            end
            else
            begin
                if (cmd.next_elem)
                begin
                    i_reg <= i_reg + crec_pkg::ADDR_W'(1);
                    r_reg <= r_wrap ? '0 : r_reg + crec_pkg::ADDR_W'(1);
                end
                if (cmd.commit && !map_valid_reg[y_idx])
                begin
                    map_valid_reg[y_idx] <= 1'b1;
                    map_used_reg[x_idx]  <= 1'b1;
                end
            end

            // Result handshake
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            equivalent_reg <= cmd.found;
            shift_reg      <= cmd.found ? crec_pkg::SHIFT_W'(k_reg) : '0;
            mismatch_reg   <= len_mismatch;
            overflow_reg   <= ref_ovf_reg || cand_ovf_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign equivalent      = equivalent_reg;
    assign shift_found     = shift_reg;
    assign length_mismatch = mismatch_reg;
    assign overflow        = overflow_reg;

endmodule

`default_nettype wire

>>> rtl/cyclic_relabeling_equivalence_check_core.sv
// ----------------------------------------------------------------------------
// cyclic_relabeling_equivalence_check_core
// Checks whether a candidate label sequence equals some rotation of a stored
// reference sequence under a one-to-one relabeling.
// ----------------------------------------------------------------------------
// Labels arrive one transaction per cycle on label_ch: req_type 0 appends to
// the reference, req_type 1 to the candidate, and last closes the sequence.
// Up to MAX_LEN labels are kept per sequence; extras are dropped and flagged
// as overflow. A reference label after a closed reference starts a fresh
// one. The candidate's last label triggers the check, which yields exactly
// one transaction on result_ch. While the check runs, label_ch.ready is low.
// Search: after the triggering label, a length mismatch answers without a
// search. Otherwise the search tries rotations k = 0, 1, ..., n-1 in order
// and stops at the first success; each rotation first clears the map marks,
// then takes each compared element through a sequence memory read, a map
// memory read, and a compare and update, and it stops at the first conflict
// or out-of-range label. The single-ported label map memory sets this pace.
// A finished result waits in an output register, so new labels are accepted
// while the previous result is still pending.
// ----------------------------------------------------------------------------
`default_nettype none

module cyclic_relabeling_equivalence_check_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    crec_label_if.sink    label_ch,
    crec_result_if.source result_ch
);

    crec_pkg::crec_cmd_t    cmd;
    crec_pkg::crec_status_t status;
    logic                   in_ready;
    logic                   accept;

    // A label transaction completes when both sides agree
    assign label_ch.ready = in_ready;
    assign accept         = label_ch.valid && in_ready;

    // Sequencer: holds label_ch off during the search and paces the datapath
    crec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (label_ch.req_type),
        .last     (label_ch.last),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // Storage, map marks, pointers and the result register
    crec_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .accept          (accept),
        .req_type        (label_ch.req_type),
        .label           (label_ch.label),
        .last            (label_ch.last),
        .out_ready       (result_ch.ready),
        .out_valid       (result_ch.valid),
        .equivalent      (result_ch.equivalent),
        .shift_found     (result_ch.shift_found),
        .length_mismatch (result_ch.length_mismatch),
        .overflow        (result_ch.overflow)
    );

endmodule

`default_nettype wire

>>> tb/tb_cyclic_relabeling_equivalence_check_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cyclic_relabeling_equivalence_check_core
// Self-checking bench for the rotation and relabeling equivalence check. It
// streams reference and candidate labels over the label channel. It mirrors
// the block in a local predictor and compares every verdict on the result
// channel against the oldest predicted one. Random idles on both sides.
// ----------------------------------------------------------------------------

module tb_cyclic_relabeling_equivalence_check_core;

    // Request codes on the label channel
    localparam bit REQ_REFERENCE = 1'b0;
    localparam bit REQ_CANDIDATE = 1'b1;

    localparam int ITEM_TARGET  = 1900;
    localparam int RESET_CYCLES = 6;
    // Allow a span longer than the worst search with no transaction on
    // either channel before giving up.
    localparam int STALL_LIMIT  = 100000;
    localparam int TAIL_CYCLES  = 20;

    typedef struct {
        bit                           req;
        logic [crec_pkg::LABEL_W-1:0] lab;
        bit                           lst;
        bit                           drain;  // hold this transaction until no verdict is pending
    } label_txn_t;

    typedef struct packed {
        logic                         equivalent;
        logic [crec_pkg::SHIFT_W-1:0] shift_found;
        logic                         length_mismatch;
        logic                         overflow;
    } verdict_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    crec_label_if  label_ch ();
    crec_result_if result_ch ();

    cyclic_relabeling_equivalence_check_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .label_ch  (label_ch),
        .result_ch (result_ch)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Pending label transactions and predicted verdicts
    // ------------------------------------------------------------------------
    label_txn_t pend_q[$];
    verdict_t   verdict_q[$];
    bit         mark_drain;

    // Predictor copy of the block's storage
    logic [crec_pkg::LABEL_W-1:0] ref_lbl  [0:crec_pkg::MAX_LEN-1];
    logic [crec_pkg::LABEL_W-1:0] cand_lbl [0:crec_pkg::MAX_LEN-1];
    int                 ref_cnt;
    int                 cand_cnt;
    bit                 ref_ovf;
    bit                 cand_ovf;
    bit                 ref_closed;

    // Bookkeeping
    int  err_cnt;
    int  labels_seen;
    int  verdicts_seen;
    int  equiv_cnt;
    int  mism_cnt;
    int  ovf_cnt;
    int  max_shift;
    int  quiet_cycles;
    bit  lbl_fire;
    int  src_gap;
    int  src_calm;
    int  snk_hold;
    int  snk_calm;
    label_txn_t drv_txn;

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    // Search rotations 0..n-1 in order; the first with a one-to-one label
    // mapping wins. Labels above MAX_LABEL never map.
    function automatic void find_rotation(input int n, output bit hit, output int k_hit);
        logic [crec_pkg::LABEL_W-1:0] image [0:crec_pkg::MAX_LABEL];
        bit                           bound [0:crec_pkg::MAX_LABEL];
        bit                           taken [0:crec_pkg::MAX_LABEL];
        bit                           ok;
        int                           k;
        int                           i;
        int                           j;
        int                           r;
        logic [crec_pkg::LABEL_W-1:0] a;
        logic [crec_pkg::LABEL_W-1:0] b;
        hit   = 1'b0;
        k_hit = 0;
        for (k = 0; k < n && !hit; k++)
        begin
            for (j = 0; j <= crec_pkg::MAX_LABEL; j++)
            begin
                bound[j] = 1'b0;
                taken[j] = 1'b0;
                image[j] = '0;
            end
            ok = 1'b1;
            r  = k;
            for (i = 0; i < n && ok; i++)
            begin
                a = ref_lbl[r];
                b = cand_lbl[i];
                if (a > crec_pkg::MAX_LABEL || b > crec_pkg::MAX_LABEL)
                    ok = 1'b0;
                else if (!bound[a])
                begin
                    if (taken[b])
                        ok = 1'b0;
                    else
                    begin
                        bound[a] = 1'b1;
                        image[a] = b;
                        taken[b] = 1'b1;
                    end
                end
                else if (image[a] != b)
                    ok = 1'b0;
                r = (r + 1 == n) ? 0 : r + 1;
            end
            if (ok)
            begin
                hit   = 1'b1;
                k_hit = k;
            end
        end
    endfunction

    // Advance the predictor by one accepted label; a closing candidate label
    // produces one predicted verdict.
    task automatic apply_label(input bit req, input logic [crec_pkg::LABEL_W-1:0] lab,
                               input bit lst);
        verdict_t v;
        bit       hit;
        int       k_hit;
        if (req == REQ_REFERENCE)
        begin
            // A reference label after a closed reference starts a new one
            if (ref_closed)
            begin
                ref_cnt    = 0;
                ref_ovf    = 1'b0;
                ref_closed = 1'b0;
            end
            if (ref_cnt < crec_pkg::MAX_LEN)
            begin
                ref_lbl[ref_cnt] = lab;
                ref_cnt++;
            end
            else
                ref_ovf = 1'b1;
            if (lst)
                ref_closed = 1'b1;
        end
        else
        begin
            if (cand_cnt < crec_pkg::MAX_LEN)
            begin
                cand_lbl[cand_cnt] = lab;
                cand_cnt++;
            end
            else
                cand_ovf = 1'b1;
            if (lst)
            begin
                // Empty reference counts as a length mismatch
                v.length_mismatch = (ref_cnt != cand_cnt) || (ref_cnt == 0);
                hit   = 1'b0;
                k_hit = 0;
                if (!v.length_mismatch)
                    find_rotation(cand_cnt, hit, k_hit);
                v.equivalent  = hit;
                v.shift_found = k_hit[crec_pkg::SHIFT_W-1:0];
                v.overflow    = ref_ovf || cand_ovf;
                verdict_q.insert(verdict_q.size(), v);
                cand_cnt = 0;
                cand_ovf = 1'b0;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
        err_cnt++;
    endtask

    task automatic check_verdict(input verdict_t got);
        verdict_t want;
        if (verdict_q.size() == 0)
            report_mismatch("result with none pending", int'(got), 0);
        else
        begin
            want = verdict_q.pop_front();
            if (got.equivalent !== want.equivalent)
                report_mismatch("equivalent", int'(got.equivalent), int'(want.equivalent));
            if (got.shift_found !== want.shift_found)
                report_mismatch("shift_found", int'(got.shift_found), int'(want.shift_found));
            if (got.length_mismatch !== want.length_mismatch)
                report_mismatch("length_mismatch", int'(got.length_mismatch),
                                int'(want.length_mismatch));
            if (got.overflow !== want.overflow)
                report_mismatch("overflow", int'(got.overflow), int'(want.overflow));
            verdicts_seen++;
            if (want.equivalent)
                equiv_cnt++;
            if (want.length_mismatch)
                mism_cnt++;
            if (want.overflow)
                ovf_cnt++;
            if (want.equivalent && int'(want.shift_found) > max_shift)
                max_shift = int'(want.shift_found);
        end
    endtask

    // Stimulus helpers: one label, or a slice of a sequence
    task automatic queue_label(input bit req, input logic [crec_pkg::LABEL_W-1:0] lab,
                               input bit lst);
        label_txn_t t;
        t.req   = req;
        t.lab   = lab;
        t.lst   = lst;
        t.drain = mark_drain;
        mark_drain = 1'b0;
        pend_q.insert(pend_q.size(), t);
    endtask

    task automatic queue_run(input bit req, input logic [crec_pkg::LABEL_W-1:0] s[$],
                             input int from, input int upto, input bit close);
        int i;
        for (i = from; i < upto; i++)
            queue_label(req, s[i], close && (i == upto - 1));
    endtask

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. Check the verdict
    // first, then feed any accepted label to the predictor; a label accepted
    // on this edge cannot have produced a verdict on the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        lbl_fire <= rst_n && label_ch.valid && label_ch.ready;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                check_verdict({result_ch.equivalent, result_ch.shift_found,
                               result_ch.length_mismatch, result_ch.overflow});
            if (label_ch.valid && label_ch.ready)
            begin
                apply_label(label_ch.req_type, label_ch.label, label_ch.last);
                labels_seen++;
            end
            if ((result_ch.valid && result_ch.ready) || (label_ch.valid && label_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: change label inputs at the falling edge. Hold the current
    // transaction until accepted, then idle for a random gap or advance to
    // the next pending one. A transaction marked drain waits until every
    // predicted verdict has come back.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!label_ch.valid || lbl_fire))
        begin
            if (src_gap > 0)
            begin
                label_ch.valid <= 1'b0;
                src_gap--;
            end
            else if (pend_q.size() != 0 && !(pend_q[0].drain && verdict_q.size() != 0))
            begin
                drv_txn = pend_q.pop_front();
                label_ch.valid    <= 1'b1;
                label_ch.req_type <= drv_txn.req;
                label_ch.label    <= drv_txn.lab;
                label_ch.last     <= drv_txn.lst;
                // Calm stretches keep the channel busy back to back
                if (src_calm > 0)
                    src_calm--;
                else
                begin
                    src_gap = pick_gap();
                    if ($urandom_range(99) < 3)
                        src_calm = $urandom_range(30, 200);
                end
            end
            else
                label_ch.valid <= 1'b0;
        end
    end

    // Result sink: stall ready at random, with calm stretches
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (snk_hold > 0)
        begin
            result_ch.ready <= 1'b0;
            snk_hold--;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            if (snk_calm > 0)
                snk_calm--;
            else
            begin
                snk_hold = pick_gap();
                if ($urandom_range(99) < 3)
                    snk_calm = $urandom_range(30, 200);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("[%0t] watchdog: no transaction for %0d cycles, %0d verdicts pending",
                 $time, STALL_LIMIT, verdict_q.size());
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [crec_pkg::LABEL_W-1:0] rseq [$];
        logic [crec_pkg::LABEL_W-1:0] cseq [$];
        logic [crec_pkg::LABEL_W-1:0] perm [0:crec_pkg::MAX_LABEL];
        logic [crec_pkg::LABEL_W-1:0] tmp;
        int                           n;
        int                           k;
        int                           h;
        int                           i;
        int                           r;
        int                           alpha;
        bit                           split;
        bit                           reuse;
        bit                           have_ref;
        bit                           drain_done;

        label_ch.valid    = 1'b0;
        label_ch.req_type = REQ_REFERENCE;
        label_ch.label    = '0;
        label_ch.last     = 1'b0;
        result_ch.ready   = 1'b0;

        // Directed: empty reference gives a length mismatch
        queue_label(REQ_CANDIDATE, 7'd5, 1'b1);
        // Label 1 and the top label 64 swapped by the relabeling, shift 0
        queue_label(REQ_REFERENCE, 7'd1, 1'b0);
        queue_label(REQ_REFERENCE, 7'd64, 1'b1);
        queue_label(REQ_CANDIDATE, 7'd64, 1'b0);
        queue_label(REQ_CANDIDATE, 7'd1, 1'b1);
        // Label zero as an ordinary label, match at shift 2
        queue_label(REQ_REFERENCE, 7'd0, 1'b0);
        queue_label(REQ_REFERENCE, 7'd0, 1'b0);
        queue_label(REQ_REFERENCE, 7'd7, 1'b1);
        queue_label(REQ_CANDIDATE, 7'd9, 1'b0);
        queue_label(REQ_CANDIDATE, 7'd3, 1'b0);
        queue_label(REQ_CANDIDATE, 7'd3, 1'b1);
        // New candidate against the same reference, shorter
        queue_label(REQ_CANDIDATE, 7'd1, 1'b0);
        queue_label(REQ_CANDIDATE, 7'd2, 1'b1);
        // New reference with labels above MAX_LABEL: never equivalent
        queue_label(REQ_REFERENCE, 7'd127, 1'b0);
        queue_label(REQ_REFERENCE, 7'd65, 1'b1);
        queue_label(REQ_CANDIDATE, 7'd127, 1'b0);
        queue_label(REQ_CANDIDATE, 7'd65, 1'b1);
        // Reference not yet closed: check uses the labels stored so far
        queue_label(REQ_REFERENCE, 7'd3, 1'b0);
        queue_label(REQ_REFERENCE, 7'd4, 1'b0);
        queue_label(REQ_CANDIDATE, 7'd8, 1'b0);
        queue_label(REQ_CANDIDATE, 7'd9, 1'b1);
        queue_label(REQ_REFERENCE, 7'd5, 1'b1);

        // Full length, only the last rotation fits: shift 63. Drain first so
        // the sender sits out a complete search.
        for (i = 0; i < crec_pkg::MAX_LEN; i++)
            queue_label(REQ_REFERENCE, (i == crec_pkg::MAX_LEN - 1) ? 7'd9 : 7'd5,
                        i == crec_pkg::MAX_LEN - 1);
        mark_drain = 1'b1;
        for (i = 0; i < crec_pkg::MAX_LEN; i++)
            queue_label(REQ_CANDIDATE, (i == 0) ? 7'd40 : 7'd33, i == crec_pkg::MAX_LEN - 1);
        // Too many labels: reference overflows, then candidate overflows too
        for (i = 0; i < crec_pkg::MAX_LEN + 2; i++)
            queue_label(REQ_REFERENCE, 7'd7, i == crec_pkg::MAX_LEN + 1);
        for (i = 0; i < crec_pkg::MAX_LEN; i++)
            queue_label(REQ_CANDIDATE, 7'd3, i == crec_pkg::MAX_LEN - 1);
        for (i = 0; i < crec_pkg::MAX_LEN + 6; i++)
            queue_label(REQ_CANDIDATE, 7'd3, i == crec_pkg::MAX_LEN + 5);

        // Random: mostly a reference followed by a rotated, relabeled
        // candidate, some corrupted; the rest is raw noise.
        have_ref   = 1'b0;
        drain_done = 1'b0;
        while (pend_q.size() < ITEM_TARGET)
        begin
            if (!drain_done && pend_q.size() > ITEM_TARGET / 2)
            begin
                mark_drain = 1'b1;
                drain_done = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 8)
            begin
                h = $urandom_range(3, 12);
                for (i = 0; i < h; i++)
                    queue_label(($urandom_range(1) == 0) ? REQ_REFERENCE : REQ_CANDIDATE,
                                crec_pkg::LABEL_W'($urandom_range(0, 127)),
                                $urandom_range(99) < 30);
                have_ref = 1'b0;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 65)
                    n = $urandom_range(1, 6);
                else if (r < 88)
                    n = $urandom_range(7, 16);
                else if (r < 96)
                    n = $urandom_range(17, 40);
                else if (r < 98)
                    n = crec_pkg::MAX_LEN;
                else
                    n = $urandom_range(crec_pkg::MAX_LEN + 1, crec_pkg::MAX_LEN + 6);

                reuse = have_ref && ($urandom_range(99) < 25);
                if (reuse)
                    n = rseq.size();
                else
                begin
                    // Small alphabets force repeated labels
                    alpha = $urandom_range(1, (n < crec_pkg::MAX_LABEL) ? n
                                                                         : crec_pkg::MAX_LABEL);
                    rseq.delete();
                    for (i = 0; i < n; i++)
                    begin
                        r = $urandom_range(99);
                        if (r < 3)
                            tmp = 7'd0;
                        else if (r < 5)
                            tmp = crec_pkg::LABEL_W'($urandom_range(crec_pkg::MAX_LABEL + 1,
                                                                    127));
                        else
                            tmp = crec_pkg::LABEL_W'($urandom_range(1, alpha));
                        rseq.insert(rseq.size(), tmp);
                    end
                end

                // Random one-to-one relabeling of 0..MAX_LABEL
                for (i = 0; i <= crec_pkg::MAX_LABEL; i++)
                    perm[i] = crec_pkg::LABEL_W'(i);
                for (i = crec_pkg::MAX_LABEL; i > 0; i--)
                begin
                    h       = $urandom_range(0, i);
                    tmp     = perm[i];
                    perm[i] = perm[h];
                    perm[h] = tmp;
                end
                k = $urandom_range(0, n - 1);
                cseq.delete();
                for (i = 0; i < n; i++)
                begin
                    tmp = rseq[(i + k) % n];
                    cseq.insert(cseq.size(), (tmp <= crec_pkg::MAX_LABEL) ? perm[tmp] : tmp);
                end

                // Break some candidates
                r = $urandom_range(99);
                if (r >= 55 && r < 78)
                    cseq[$urandom_range(0, n - 1)] =
                        crec_pkg::LABEL_W'($urandom_range(0, crec_pkg::MAX_LABEL + 2));
                else if (r >= 78 && r < 90)
                begin
                    if ($urandom_range(1) == 1 && n > 1)
                        void'(cseq.pop_back());
                    else
                        cseq.insert(cseq.size(),
                                    crec_pkg::LABEL_W'($urandom_range(1, crec_pkg::MAX_LABEL)));
                end
                else if (r >= 90 && n > 1)
                begin
                    h       = $urandom_range(0, n - 1);
                    i       = $urandom_range(0, n - 1);
                    tmp     = cseq[h];
                    cseq[h] = cseq[i];
                    cseq[i] = tmp;
                end

                // Sometimes start the candidate before the reference arrives
                split = !reuse && cseq.size() > 1 && ($urandom_range(99) < 15);
                h     = split ? $urandom_range(1, cseq.size() - 1) : 0;
                if (split)
                    queue_run(REQ_CANDIDATE, cseq, 0, h, 1'b0);
                if (!reuse)
                    queue_run(REQ_REFERENCE, rseq, 0, rseq.size(), 1'b1);
                queue_run(REQ_CANDIDATE, cseq, h, cseq.size(), 1'b1);
                have_ref = 1'b1;
            end
        end

        // Hold reset, then release on a falling edge
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every transaction to go out and every verdict to return
        while (pend_q.size() != 0 || label_ch.valid)
            @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d label transactions and %0d check verdicts.",
                 labels_seen, verdicts_seen);
        $display("Verdicts: %0d equivalent (largest shift %0d), %0d length mismatch, %0d %s",
                 equiv_cnt, max_shift, mism_cnt, ovf_cnt, "overflow.");
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
